FILE: rtl/tac_pkg.sv
// Shared types, character codes and register indexes for the tripwire alarm controller.
// Used by tac_step and tripwire_alarm_controller_unit; no dependencies.
`timescale 1ns / 1ps
package tac_pkg;

    localparam logic [7:0] CH_SET   = 8'h21;
    localparam logic [7:0] CH_QUERY = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [3:0] HITS_MAX = 4'd15;

    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_TRIP_COUNT = 2'd2;

    localparam logic [15:0] RANGE_LOW_RST  = 16'd120;
    localparam logic [15:0] RANGE_HIGH_RST = 16'd600;
    localparam logic [3:0]  TRIP_COUNT_RST = 4'd3;
    localparam logic [3:0]  LEVEL_RST      = 4'd9;

    localparam logic [1:0] LED_GREEN = 2'd0;
    localparam logic [1:0] LED_BLUE  = 2'd1;
    localparam logic [1:0] LED_RED   = 2'd2;

    typedef enum logic [1:0] {
        FK_NONE  = 2'd0,
        FK_REPLY = 2'd1,
        FK_ALERT = 2'd2
    } frame_kind_t;

    typedef struct packed {
        logic [15:0] range_low;
        logic [15:0] range_high;
        logic [3:0]  trip_count;
    } cfg_t;

    typedef struct packed {
        logic       armed;
        logic       latched;
        logic       muted;
        logic [3:0] level;
        logic [3:0] hits;
        logic       alert_done;
    } state_t;

    typedef struct packed {
        logic        func;
        logic [15:0] distance;
        logic        sample_ok;
        logic [7:0]  cmd_byte0;
        logic [7:0]  cmd_byte1;
        logic [7:0]  cmd_byte2;
        logic [7:0]  cmd_byte3;
    } in_item_t;

    typedef struct packed {
        frame_kind_t frame_kind;
        logic [7:0]  frame_byte0;
        logic [7:0]  frame_byte1;
        logic [7:0]  frame_byte2;
        logic [7:0]  frame_byte3;
        logic        alarm_pulse;
        logic        is_armed;
        logic        is_triggered;
        logic        is_muted;
        logic [3:0]  light_level;
        logic [1:0]  led_colour;
        logic        sound_on;
    } out_item_t;

endpackage

FILE: rtl/tac_step.sv
// Combinational update for one request: next controller state and the result item.
// Depends on tac_pkg for the state, item and configuration types.
`timescale 1ns / 1ps
module tac_step
(
    input  tac_pkg::cfg_t      cfg,
    input  tac_pkg::state_t    state,
    input  tac_pkg::in_item_t  item,
    output tac_pkg::state_t    state_next,
    output tac_pkg::out_item_t result
);

    logic       in_window;
    logic [3:0] hits_new;
    logic       pulse;
    logic       replied;
    logic [7:0] reply_char;

    always_comb
    begin
        state_next = state;
        result     = '0;
        result.frame_kind = tac_pkg::FK_NONE;
        pulse      = 1'b0;
        replied    = 1'b0;
        reply_char = tac_pkg::CH_ZERO;
        in_window  = state.armed && (item.distance > cfg.range_low)
                     && (item.distance < cfg.range_high);
        hits_new   = '0;
        if (in_window)
        begin
            hits_new = (state.hits == tac_pkg::HITS_MAX) ? state.hits : state.hits + 4'd1;
        end

        if (!item.func)
        begin
            if (item.sample_ok)
            begin
                state_next.hits = hits_new;
                if ((hits_new > cfg.trip_count) && !state.latched)
                begin
                    state_next.latched    = 1'b1;
                    state_next.alert_done = 1'b0;
                    pulse                 = 1'b1;
                end
            end
        end
        else
        begin
            case (item.cmd_byte0)
                tac_pkg::CH_SET:
                begin
                    case (item.cmd_byte1)
                        tac_pkg::CH_A:
                        begin
                            if (item.cmd_byte2 == tac_pkg::CH_ZERO)
                            begin
                                state_next.armed   = 1'b0;
                                state_next.latched = 1'b0;
                            end
                            else if (item.cmd_byte2 == tac_pkg::CH_ONE)
                            begin
                                state_next.armed   = 1'b1;
                                state_next.latched = 1'b0;
                            end
                        end
                        tac_pkg::CH_D:
                        begin
                            state_next.latched = 1'b0;
                        end
                        tac_pkg::CH_M:
                        begin
                            state_next.muted = ~state.muted;
                        end
                        tac_pkg::CH_B:
                        begin
                            if (item.cmd_byte2 inside {[tac_pkg::CH_ZERO:tac_pkg::CH_NINE]})
                            begin
                                state_next.level = 4'(item.cmd_byte2 - tac_pkg::CH_ZERO);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                tac_pkg::CH_QUERY:
                begin
                    replied = 1'b1;
                    case (item.cmd_byte1)
                        tac_pkg::CH_T: reply_char = state.latched ? tac_pkg::CH_ONE
                                                                  : tac_pkg::CH_ZERO;
                        tac_pkg::CH_A: reply_char = state.armed ? tac_pkg::CH_ONE
                                                                : tac_pkg::CH_ZERO;
                        tac_pkg::CH_M: reply_char = state.muted ? tac_pkg::CH_ONE
                                                                : tac_pkg::CH_ZERO;
                        tac_pkg::CH_B: reply_char = tac_pkg::CH_ZERO + {4'd0, state.level};
                        default:       replied = 1'b0;
                    endcase
                    if (replied)
                    begin
                        result.frame_kind  = tac_pkg::FK_REPLY;
                        result.frame_byte0 = tac_pkg::CH_QUERY;
                        result.frame_byte1 = item.cmd_byte1;
                        result.frame_byte2 = reply_char;
                        result.frame_byte3 = reply_char;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (!replied && state_next.latched && !state_next.alert_done)
        begin
            result.frame_kind     = tac_pkg::FK_ALERT;
            result.frame_byte0    = tac_pkg::CH_SET;
            result.frame_byte1    = tac_pkg::CH_SET;
            result.frame_byte2    = tac_pkg::CH_SET;
            result.frame_byte3    = tac_pkg::CH_SET;
            state_next.alert_done = 1'b1;
        end

        result.alarm_pulse  = pulse;
        result.is_armed     = state_next.armed;
        result.is_triggered = state_next.latched;
        result.is_muted     = state_next.muted;
        result.light_level  = state_next.level;
        result.led_colour   = state_next.latched ? tac_pkg::LED_RED
                            : (state_next.armed ? tac_pkg::LED_BLUE : tac_pkg::LED_GREEN);
        result.sound_on     = state_next.latched && !state_next.muted;
    end

    logic unused_byte3;
    assign unused_byte3 = ^item.cmd_byte3;

endmodule

FILE: rtl/tripwire_alarm_controller_unit.sv
// Tripwire alarm controller top level: stream ports, APB registers, input and result registers.
// Depends on tac_pkg and tac_step.
// A request passes through the input register and then the result register to the master side.
// One request per cycle unless m_tready stalls; the state update in tac_step is combinational.
// Reset (rst_n low, asynchronous): disarmed, alarm clear, muted, level 9, counters clear,
// window 120..600, trip count 3, both pipeline registers empty.
`timescale 1ns / 1ps
module tripwire_alarm_controller_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // distance[15:0], sample_ok[16], cmd_byte0..3[48:17], zeros
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // frame_byte0..3[31:0], alarm_pulse, is_armed,
                                   // is_triggered, is_muted, light_level[39:36],
                                   // led_colour[41:40], sound_on[42], zeros
    output logic [1:0]  m_tuser,   // frame_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tac_pkg::cfg_t      cfg_reg;
    tac_pkg::state_t    state_reg;
    tac_pkg::state_t    state_next;
    tac_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    tac_pkg::out_item_t out_item_reg;
    tac_pkg::out_item_t out_item_next;
    logic               out_valid_reg;
    logic               out_load;
    logic               advance;
    logic               cfg_write;
    logic [1:0]         reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low  <= tac_pkg::RANGE_LOW_RST;
            cfg_reg.range_high <= tac_pkg::RANGE_HIGH_RST;
            cfg_reg.trip_count <= tac_pkg::TRIP_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                tac_pkg::REG_RANGE_LOW:  cfg_reg.range_low  <= pwdata[15:0];
                tac_pkg::REG_RANGE_HIGH: cfg_reg.range_high <= pwdata[15:0];
                tac_pkg::REG_TRIP_COUNT: cfg_reg.trip_count <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            tac_pkg::REG_RANGE_LOW:  prdata = {16'd0, cfg_reg.range_low};
            tac_pkg::REG_RANGE_HIGH: prdata = {16'd0, cfg_reg.range_high};
            tac_pkg::REG_TRIP_COUNT: prdata = {28'd0, cfg_reg.trip_count};
            default:                 prdata = '0;
        endcase
    end

    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func      <= s_tuser;
            in_item_reg.distance  <= s_tdata[15:0];
            in_item_reg.sample_ok <= s_tdata[16];
            in_item_reg.cmd_byte0 <= s_tdata[24:17];
            in_item_reg.cmd_byte1 <= s_tdata[32:25];
            in_item_reg.cmd_byte2 <= s_tdata[40:33];
            in_item_reg.cmd_byte3 <= s_tdata[48:41];
        end
    end

    tac_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.armed      <= 1'b0;
            state_reg.latched    <= 1'b0;
            state_reg.muted      <= 1'b1;
            state_reg.level      <= tac_pkg::LEVEL_RST;
            state_reg.hits       <= '0;
            state_reg.alert_done <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.frame_kind;
    assign m_tdata  = {5'd0,
                       out_item_reg.sound_on,
                       out_item_reg.led_colour,
                       out_item_reg.light_level,
                       out_item_reg.is_muted,
                       out_item_reg.is_triggered,
                       out_item_reg.is_armed,
                       out_item_reg.alarm_pulse,
                       out_item_reg.frame_byte3,
                       out_item_reg.frame_byte2,
                       out_item_reg.frame_byte1,
                       out_item_reg.frame_byte0};

    // A newly latched alarm always leaves with its pulse in the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.latched) |-> (out_valid_reg && out_item_reg.alarm_pulse))
        else $error("alarm latched without a pulse in the result");

    // The state only moves when a request passes into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a request advancing");

    // An alert frame goes out only while the alarm is latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.frame_kind == tac_pkg::FK_ALERT)
        |-> out_item_reg.is_triggered)
        else $error("alert frame while the alarm is clear");

    // The brightness level never leaves the digit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.level <= tac_pkg::LEVEL_RST)
        else $error("brightness level out of range");

endmodule
